[hdl/avbm_pkg.sv]
// avbm_pkg: shared types, constants and the envelope step function
// for the adsr voice bank mixer; no dependencies
`timescale 1ns / 1ps
package avbm_pkg;

   localparam int VOICES_DEF = 4;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;
   localparam logic [22:0] MAX_LEVEL_RST = 23'd8323072;

   // input function codes
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_RELEASE = 2'd2;

   // register indexes
   localparam logic REG_MODE = 1'b0;
   localparam logic REG_MAX = 1'b1;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_START,
      CMD_RELEASE
   } cmd_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ATTACK,
      PH_DECAY,
      PH_SUSTAIN,
      PH_RELEASE
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EMIT,
      BK_DIV_START,
      BK_DIV_WAIT,
      BK_MIX
   } back_state_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0] voice;
      logic [6:0] attack;
      logic [6:0] decay;
      logic [6:0] rel;
      logic [6:0] sustain;
      logic [23:0] half_period;
      logic [31:0] time_count;
   } cmd_type;

   typedef struct packed {
      logic [6:0] attack;
      logic [6:0] decay;
      logic [6:0] rel;
      logic [6:0] sustain;
   } voice_type;

   typedef struct packed {
      phase_type phase;
      logic signed [24:0] level;
   } env_type;

   typedef struct packed {
      logic output_mode;
      logic [22:0] max_level;
   } cfg_type;

   // result fields, lowest bits last
   typedef struct packed {
      logic [7:0] modulation;
      logic [2:0] active_voices;
      logic [22:0] voice_level;
      logic voice_enable;
      logic [1:0] voice_index;
   } rsp_type;

   function automatic logic signed [24:0] rate_step(logic [6:0] rate);
      logic [7:0] diff;
      diff = 8'd128 - {1'b0, rate};
      return $signed({9'b0, diff, 8'b0});
   endfunction

   // one tick of one envelope
   function automatic env_type env_step(env_type e, voice_type p, logic [22:0] maxl);
      logic signed [24:0] lvl;
      logic signed [24:0] sus;
      logic signed [24:0] mx;
      phase_type ph;
      env_type r;
      lvl = e.level;
      ph = e.phase;
      sus = $signed({2'b0, p.sustain, 16'b0});
      mx = $signed({2'b0, maxl});
      case (ph)
         PH_ATTACK: begin
            if (p.attack != 7'd0) lvl = lvl + rate_step(p.attack);
            else ph = PH_SUSTAIN;
            if (lvl >= mx) begin
               lvl = mx;
               ph = PH_DECAY;
            end
         end
         PH_DECAY: begin
            if (p.decay != 7'd0) lvl = lvl - rate_step(p.decay);
            else ph = PH_SUSTAIN;
            if (lvl <= sus) begin
               lvl = sus;
               ph = PH_SUSTAIN;
            end
         end
         PH_SUSTAIN: lvl = sus;
         PH_RELEASE: begin
            if (p.rel != 7'd0) lvl = lvl - rate_step(p.rel);
            else lvl = '0;
            if (lvl <= 25'sd0) begin
               lvl = '0;
               ph = PH_IDLE;
            end
         end
         default: ;
      endcase
      r.phase = ph;
      r.level = lvl;
      return r;
   endfunction

endpackage

[hdl/adsr_voice_bank_mixer.sv]
// adsr_voice_bank_mixer: top level with configuration registers
// depends on avbm_pkg, avbm_front, avbm_back
//
// Usage: items come in on the req_ stream; tuser carries the function
// (tick, start voice, release voice), tdata the voice settings and time.
// Start and release items give no result. A tick steps every envelope and
// gives either one result per voice (tlast on the final one) or, in mixed
// mode, a single modulation result, on the rsp_ stream.
// The csr_ port holds output_mode at address 0 and max_level at address 4;
// write them only while the block is idle.
// A mixed tick waits on the shared 32-step divider, which finds each
// voice's square-wave polarity, one voice after another.
// A two-entry command queue sits between the input and the back end, so
// items are taken while results wait; a stalled receiver holds the output
// register and the back end waits for it. Reset puts all voices idle at
// level zero, clears the queue and loads the register defaults.
`timescale 1ns / 1ps
module adsr_voice_bank_mixer #(
   parameter int VOICES = avbm_pkg::VOICES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [1:0] req_tuser,    // func
   input  logic [87:0] req_tdata,   // voice, attack_rate, decay_rate, release_rate,
                                    // sustain_level, half_period, time_count, zero fill
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [39:0] rsp_tdata,   // voice_index, voice_enable, voice_level,
                                    // active_voices, modulation, zero fill
   output logic rsp_tlast,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   avbm_pkg::cfg_type cfg_ff, cfg_in;
   avbm_pkg::cmd_type q_cmd;
   avbm_pkg::rsp_type rsp_fields;
   logic q_valid, q_pop, csr_write;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            avbm_pkg::REG_MODE: cfg_in.output_mode = csr_pwdata[0];
            avbm_pkg::REG_MAX: cfg_in.max_level = csr_pwdata[22:0];
            default: ;
         endcase
      end
      case (csr_paddr[2])
         avbm_pkg::REG_MODE: csr_prdata = {31'b0, cfg_ff.output_mode};
         avbm_pkg::REG_MAX: csr_prdata = {9'b0, cfg_ff.max_level};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_mode <= 1'b0;
         cfg_ff.max_level <= avbm_pkg::MAX_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   avbm_front #(.VOICES(VOICES)) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .q_pop(q_pop)
   );

   avbm_back #(.VOICES(VOICES)) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .q_pop(q_pop),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_fields(rsp_fields),
      .rsp_tlast(rsp_tlast)
   );

   assign rsp_tdata = {3'b0, rsp_fields};

   // checks
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue popped while empty");

   a_enable_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_fields.voice_enable == (rsp_fields.voice_level != '0)))
      else $error("enable does not match level");

   a_mixed_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cfg_ff.output_mode |-> rsp_tlast && rsp_fields.voice_level == '0)
      else $error("mixed result carries voice fields");

   a_active_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_fields.active_voices) <= 32'(VOICES))
      else $error("active count above voice count");

endmodule

[hdl/avbm_front.sv]
// avbm_front: accepts input items, drops meaningless ones, queues commands
// depends on avbm_pkg
`timescale 1ns / 1ps
module avbm_front #(
   parameter int VOICES = avbm_pkg::VOICES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [1:0] req_tuser,    // func
   input  logic [87:0] req_tdata,   // voice, attack, decay, release, sustain, half_period, time
   output logic q_valid,
   output avbm_pkg::cmd_type q_cmd,
   input  logic q_pop
);

   avbm_pkg::cmd_type mem_ff [avbm_pkg::QDEPTH];
   logic [avbm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [avbm_pkg::QCNT_W-1:0] count_ff, count_in;
   avbm_pkg::cmd_type cmd;
   logic keep, push;

   // classify the item
   always_comb begin
      cmd.voice = req_tdata[1:0];
      cmd.attack = req_tdata[8:2];
      cmd.decay = req_tdata[15:9];
      cmd.rel = req_tdata[22:16];
      cmd.sustain = req_tdata[29:23];
      cmd.half_period = req_tdata[53:30];
      cmd.time_count = req_tdata[85:54];
      cmd.kind = avbm_pkg::CMD_TICK;
      keep = 1'b0;
      case (req_tuser)
         avbm_pkg::FUNC_TICK: keep = 1'b1;
         avbm_pkg::FUNC_START: begin
            cmd.kind = avbm_pkg::CMD_START;
            keep = 32'(req_tdata[1:0]) < 32'(VOICES);
         end
         avbm_pkg::FUNC_RELEASE: begin
            cmd.kind = avbm_pkg::CMD_RELEASE;
            keep = 32'(req_tdata[1:0]) < 32'(VOICES);
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_tready = count_ff != avbm_pkg::QCNT_W'(avbm_pkg::QDEPTH);
   assign push = req_tvalid && req_tready && keep;
   assign q_valid = count_ff != '0;
   assign q_cmd = mem_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= cmd;
   end

endmodule

[hdl/avbm_div.sv]
// avbm_div: restoring divider, one quotient bit a cycle, gives quotient bit 0
// no dependencies
`timescale 1ns / 1ps
module avbm_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] dividend,
   input  logic [23:0] divisor,
   output logic done,
   output logic quot_lsb
);

   logic busy_ff, busy_in, done_ff, done_in, qbit_ff, qbit_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [23:0] rem_ff, rem_in, div_ff, div_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [24:0] trial;

   // one step of long division
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      qbit_in = qbit_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      dvd_in = dvd_ff;
      trial = {rem_ff, dvd_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         div_in = divisor;
         dvd_in = dividend;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[30:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 24'(trial - {1'b0, div_ff});
            qbit_in = 1'b1;
         end else begin
            rem_in = trial[23:0];
            qbit_in = 1'b0;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      qbit_ff <= qbit_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      dvd_ff <= dvd_in;
   end

   assign done = done_ff;
   assign quot_lsb = qbit_ff;

endmodule

[hdl/avbm_back.sv]
// avbm_back: voice state, envelope stepping, result sequencing and mixing
// depends on avbm_pkg and avbm_div
`timescale 1ns / 1ps
module avbm_back #(
   parameter int VOICES = avbm_pkg::VOICES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  avbm_pkg::cfg_type cfg,
   input  logic q_valid,
   input  avbm_pkg::cmd_type q_cmd,
   output logic q_pop,
   input  logic rsp_tready,
   output logic rsp_tvalid,
   output avbm_pkg::rsp_type rsp_fields,
   output logic rsp_tlast
);

   localparam int VIDX_W = VOICES > 1 ? $clog2(VOICES) : 1;
   localparam int ACT_W = $clog2(VOICES + 1);
   localparam int SUM_W = 25 + $clog2(VOICES) + 1;
   localparam logic signed [SUM_W-1:0] MIX_HI = 127;
   localparam logic signed [SUM_W-1:0] MIX_LO = -128;
   localparam logic [VIDX_W-1:0] LAST_V = VIDX_W'(VOICES - 1);

   avbm_pkg::env_type env_ff [VOICES];
   avbm_pkg::env_type env_in [VOICES];
   avbm_pkg::voice_type par_ff [VOICES];
   avbm_pkg::voice_type par_in [VOICES];
   logic [23:0] hp_ff [VOICES];
   logic [23:0] hp_in [VOICES];
   avbm_pkg::back_state_type state_ff, state_in;
   logic [VIDX_W-1:0] cnt_ff, cnt_in, vi;
   logic [31:0] time_ff, time_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in, mixed;
   logic valid_ff, valid_in, last_ff, last_in;
   avbm_pkg::rsp_type out_ff, out_in;
   logic [ACT_W-1:0] active;
   logic out_free, div_start, div_done, div_q;
   logic signed [24:0] cur_lvl;

   avbm_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(time_ff),
      .divisor(hp_ff[cnt_ff]),
      .done(div_done),
      .quot_lsb(div_q)
   );

   // voices above zero
   always_comb begin
      active = '0;
      for (int v = 0; v < VOICES; v++) begin
         if (env_ff[v].level > 25'sd0) active = active + 1'b1;
      end
   end

   assign out_free = !valid_ff || rsp_tready;
   assign vi = VIDX_W'(q_cmd.voice);
   assign cur_lvl = env_ff[cnt_ff].level;
   assign mixed = sum_ff >>> 16;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      time_in = time_ff;
      sum_in = sum_ff;
      env_in = env_ff;
      par_in = par_ff;
      hp_in = hp_ff;
      valid_in = rsp_tready ? 1'b0 : valid_ff;
      last_in = last_ff;
      out_in = out_ff;
      q_pop = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         avbm_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.kind)
                  avbm_pkg::CMD_START: begin
                     par_in[vi].attack = q_cmd.attack;
                     par_in[vi].decay = q_cmd.decay;
                     par_in[vi].rel = q_cmd.rel;
                     par_in[vi].sustain = q_cmd.sustain;
                     hp_in[vi] = q_cmd.half_period != '0 ? q_cmd.half_period : 24'd1;
                     env_in[vi].phase = avbm_pkg::PH_ATTACK;
                  end
                  avbm_pkg::CMD_RELEASE: env_in[vi].phase = avbm_pkg::PH_RELEASE;
                  avbm_pkg::CMD_TICK: begin
                     for (int v = 0; v < VOICES; v++) begin
                        env_in[v] = avbm_pkg::env_step(env_ff[v], par_ff[v], cfg.max_level);
                     end
                     time_in = q_cmd.time_count;
                     cnt_in = '0;
                     sum_in = '0;
                     state_in = cfg.output_mode ? avbm_pkg::BK_DIV_START : avbm_pkg::BK_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         // one per-voice item a cycle while the output register is free
         avbm_pkg::BK_EMIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               out_in.voice_index = 2'(cnt_ff);
               out_in.voice_enable = cur_lvl > 25'sd0;
               out_in.voice_level = cur_lvl[22:0];
               out_in.active_voices = 3'(active);
               out_in.modulation = '0;
               last_in = cnt_ff == LAST_V;
               if (cnt_ff == LAST_V) state_in = avbm_pkg::BK_IDLE;
               else cnt_in = cnt_ff + 1'b1;
            end
         end
         avbm_pkg::BK_DIV_START: begin
            div_start = 1'b1;
            state_in = avbm_pkg::BK_DIV_WAIT;
         end
         // square-wave polarity decides the sign of each active voice
         avbm_pkg::BK_DIV_WAIT: begin
            if (div_done) begin
               if (cur_lvl > 25'sd0) begin
                  if (div_q) sum_in = sum_ff + SUM_W'(cur_lvl);
                  else sum_in = sum_ff - SUM_W'(cur_lvl);
               end
               if (cnt_ff == LAST_V) begin
                  state_in = avbm_pkg::BK_MIX;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  state_in = avbm_pkg::BK_DIV_START;
               end
            end
         end
         // clamp and offset the mix
         avbm_pkg::BK_MIX: begin
            if (out_free) begin
               valid_in = 1'b1;
               last_in = 1'b1;
               out_in.voice_index = '0;
               out_in.voice_enable = 1'b0;
               out_in.voice_level = '0;
               out_in.active_voices = 3'(active);
               if (mixed > MIX_HI) out_in.modulation = 8'hFF;
               else if (mixed < MIX_LO) out_in.modulation = 8'h00;
               else out_in.modulation = mixed[7:0] ^ 8'h80;
               state_in = avbm_pkg::BK_IDLE;
            end
         end
         default: state_in = avbm_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= avbm_pkg::BK_IDLE;
         valid_ff <= 1'b0;
         for (int v = 0; v < VOICES; v++) begin
            env_ff[v] <= '{phase: avbm_pkg::PH_IDLE, level: '0};
            par_ff[v] <= '0;
            hp_ff[v] <= 24'd1;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         env_ff <= env_in;
         par_ff <= par_in;
         hp_ff <= hp_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      time_ff <= time_in;
      sum_ff <= sum_in;
      last_ff <= last_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_fields = out_ff;
   assign rsp_tlast = last_ff;

endmodule
